>>> src/lbds_pkg.sv
// Shared types, codes and constants for the lift build/dismantle sequencer.
`timescale 1ns / 1ps

package lbds_pkg;

   // Wait counter width default
   localparam int COUNT_WIDTH_DEF = 8;

   // Configuration register file
   localparam int CFG_WIDTH  = 8;
   localparam int CFG_NUM    = 8;
   localparam int CFG_IDX_W  = 3;
   localparam int CSR_ADDR_W = 4;

   localparam logic [CSR_ADDR_W-1:0] CFG_NUM_ADDR = CSR_ADDR_W'(CFG_NUM);

   // Register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_WAIT_HOOKS_OUT_BUILD     = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIFT_BUILD          = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_TIME_PLACE_BUILD         = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_WAIT_HOOKS_IN_BUILD      = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_AT_TOP             = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_TIME_LOWER_DISMANTLE     = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_WAIT_HOOKS_OUT_DISMANTLE = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_WAIT_BEFORE_HOOKS_IN     = 3'd7;

   typedef logic [CFG_NUM-1:0][CFG_WIDTH-1:0] cfg_type;

   // Reset values, entry i is register i
   localparam cfg_type CFG_RESET = {
      8'd10, 8'd6, 8'd4, 8'd3, 8'd2, 8'd4, 8'd2, 8'd10
   };

   // Motor drive codes
   localparam logic [1:0] MOT_STOP = 2'd0;
   localparam logic [1:0] MOT_UP   = 2'd1;
   localparam logic [1:0] MOT_DOWN = 2'd2;

   // LED bit positions
   localparam int LED_B = 0;
   localparam int LED_D = 1;
   localparam int LED_W = 2;
   localparam int LED_E = 3;

   // Step codes held in next_build / next_dismantle
   localparam logic [1:0] STEP_ONE   = 2'd0;
   localparam logic [1:0] STEP_TWO   = 2'd1;
   localparam logic [1:0] STEP_THREE = 2'd2;
   localparam logic [1:0] STEP_FOUR  = 2'd3;

   // Phase evaluations chained within one tick (longest chain is seven)
   localparam int STEP_PASSES = 7;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_B1_HOOKWAIT,
      PH_B1_LIFT,
      PH_B2_UP,
      PH_B3_PLACE,
      PH_B4_HOOKWAIT,
      PH_B4_DOWN,
      PH_D1_UP,
      PH_D1_PAUSE,
      PH_D1_LOWER,
      PH_D2_HOOKWAIT,
      PH_D2_UP,
      PH_D3_DOWN,
      PH_D3_WAIT
   } phase_type;

   typedef struct packed {
      logic btn_build;
      logic btn_dismantle;
      logic emergency_stop;
      logic top_switch;
      logic bottom_switch;
   } sense_type;

   // Sequencer context passed from one phase evaluation to the next
   typedef struct packed {
      phase_type  phase;
      logic [1:0] next_build;
      logic [1:0] next_dismantle;
      logic [1:0] motor;
      logic       hooks;
      logic [3:0] leds;
      logic       check;
      logic       run;
   } ctx_type;

endpackage

>>> src/lbds_csr.sv
// Configuration register file for the sequencer timing values.
`timescale 1ns / 1ps

module lbds_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [lbds_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [lbds_pkg::CFG_WIDTH-1:0]     csr_wdata,
   output lbds_pkg::cfg_type                  cfg
);
   import lbds_pkg::*;

   cfg_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= CFG_RESET;
      end else if (csr_valid && (csr_index < CFG_NUM_ADDR)) begin
         regs_ff[csr_index[CFG_IDX_W-1:0]] <= csr_wdata;
      end
   end

   assign cfg = regs_ff;

endmodule

>>> src/lbds_pass.sv
// One phase evaluation of the sequencer; chained several times per tick.
`timescale 1ns / 1ps

module lbds_pass #(
   parameter int COUNT_WIDTH = lbds_pkg::COUNT_WIDTH_DEF
) (
   input  lbds_pkg::cfg_type          cfg,
   input  lbds_pkg::sense_type        sense,
   input  lbds_pkg::ctx_type          ctx_i,
   input  logic [COUNT_WIDTH-1:0]     cnt_i,
   output lbds_pkg::ctx_type          ctx_o,
   output logic [COUNT_WIDTH-1:0]     cnt_o
);
   import lbds_pkg::*;

   localparam int LoadW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam logic [LoadW-1:0] CntMax = LoadW'((1 << COUNT_WIDTH) - 1);

   // saturate a register value into the counter
   function automatic logic [COUNT_WIDTH-1:0] load_wait(input logic [CFG_WIDTH-1:0] v);
      logic [LoadW-1:0] ext;
      ext = LoadW'(v);
      if (ext > CntMax) begin
         ext = CntMax;
      end
      return COUNT_WIDTH'(ext);
   endfunction

   logic waiting;
   logic reached;
   logic [1:0] seek_dir;

   assign waiting = (cnt_i != '0);

   always_comb begin
      reached  = 1'b0;
      seek_dir = MOT_STOP;
      case (ctx_i.phase)
         PH_B2_UP, PH_D1_UP, PH_D2_UP: begin
            reached  = sense.top_switch;
            seek_dir = MOT_UP;
         end
         PH_B4_DOWN, PH_D3_DOWN: begin
            reached  = sense.bottom_switch;
            seek_dir = MOT_DOWN;
         end
         default: begin
            reached  = 1'b0;
            seek_dir = MOT_STOP;
         end
      endcase
   end

   always_comb begin
      ctx_o = ctx_i;
      cnt_o = cnt_i;
      if (ctx_i.run) begin
         unique case (ctx_i.phase)
            PH_IDLE: begin
               if (ctx_i.check) begin
                  ctx_o.check = 1'b0;
                  if (sense.btn_dismantle) begin
                     ctx_o.leds[LED_D] = 1'b1;
                     unique case (ctx_i.next_dismantle)
                        STEP_ONE: begin
                           ctx_o.leds[LED_W] = 1'b1;
                           ctx_o.phase = PH_D1_UP;
                        end
                        STEP_TWO: begin
                           ctx_o.hooks = 1'b1;
                           cnt_o = load_wait(cfg[CFG_WAIT_HOOKS_OUT_DISMANTLE]);
                           ctx_o.phase = PH_D2_HOOKWAIT;
                        end
                        STEP_THREE: begin
                           ctx_o.phase = PH_D3_DOWN;
                        end
                        STEP_FOUR: begin
                           // unused code: only reset the step
                           ctx_o.next_dismantle = STEP_ONE;
                           ctx_o.phase = PH_IDLE;
                           ctx_o.run = 1'b0;
                        end
                     endcase
                  end else begin
                     ctx_o.run = 1'b0;
                  end
               end else begin
                  ctx_o.leds[LED_E] = sense.emergency_stop;
                  if (sense.emergency_stop) begin
                     ctx_o.run = 1'b0;
                  end else if (sense.btn_build) begin
                     ctx_o.leds[LED_B] = 1'b1;
                     unique case (ctx_i.next_build)
                        STEP_ONE: begin
                           ctx_o.leds[LED_W] = 1'b1;
                           ctx_o.hooks = 1'b1;
                           cnt_o = load_wait(cfg[CFG_WAIT_HOOKS_OUT_BUILD]);
                           ctx_o.phase = PH_B1_HOOKWAIT;
                        end
                        STEP_TWO: begin
                           ctx_o.phase = PH_B2_UP;
                        end
                        STEP_THREE: begin
                           ctx_o.motor = MOT_DOWN;
                           cnt_o = load_wait(cfg[CFG_TIME_PLACE_BUILD]);
                           ctx_o.phase = PH_B3_PLACE;
                        end
                        STEP_FOUR: begin
                           ctx_o.hooks = 1'b0;
                           cnt_o = load_wait(cfg[CFG_WAIT_HOOKS_IN_BUILD]);
                           ctx_o.phase = PH_B4_HOOKWAIT;
                        end
                     endcase
                  end else begin
                     ctx_o.check = 1'b1;
                  end
               end
            end
            PH_B1_HOOKWAIT, PH_B1_LIFT, PH_B3_PLACE, PH_B4_HOOKWAIT,
            PH_D1_PAUSE, PH_D1_LOWER, PH_D2_HOOKWAIT, PH_D3_WAIT: begin
               if (waiting) begin
                  cnt_o = cnt_i - COUNT_WIDTH'(1);
                  ctx_o.run = 1'b0;
               end else begin
                  unique case (ctx_i.phase)
                     PH_B1_HOOKWAIT: begin
                        ctx_o.motor = MOT_UP;
                        cnt_o = load_wait(cfg[CFG_TIME_LIFT_BUILD]);
                        ctx_o.phase = PH_B1_LIFT;
                     end
                     PH_B1_LIFT: begin
                        ctx_o.motor = MOT_STOP;
                        ctx_o.next_build = STEP_TWO;
                        ctx_o.phase = PH_IDLE;
                        ctx_o.check = 1'b1;
                     end
                     PH_B3_PLACE: begin
                        ctx_o.motor = MOT_STOP;
                        ctx_o.next_build = STEP_FOUR;
                        ctx_o.phase = PH_IDLE;
                        ctx_o.check = 1'b1;
                     end
                     PH_B4_HOOKWAIT: begin
                        ctx_o.phase = PH_B4_DOWN;
                     end
                     PH_D1_PAUSE: begin
                        ctx_o.motor = MOT_DOWN;
                        cnt_o = load_wait(cfg[CFG_TIME_LOWER_DISMANTLE]);
                        ctx_o.phase = PH_D1_LOWER;
                     end
                     PH_D1_LOWER: begin
                        ctx_o.motor = MOT_STOP;
                        ctx_o.next_dismantle = STEP_TWO;
                        ctx_o.phase = PH_IDLE;
                        ctx_o.run = 1'b0;
                     end
                     PH_D2_HOOKWAIT: begin
                        ctx_o.phase = PH_D2_UP;
                     end
                     default: begin
                        // end of dismantle step three
                        ctx_o.hooks = 1'b0;
                        ctx_o.leds[LED_D] = 1'b0;
                        ctx_o.leds[LED_W] = 1'b0;
                        ctx_o.next_dismantle = STEP_ONE;
                        ctx_o.phase = PH_IDLE;
                        ctx_o.run = 1'b0;
                     end
                  endcase
               end
            end
            PH_B2_UP, PH_B4_DOWN, PH_D1_UP, PH_D2_UP, PH_D3_DOWN: begin
               if (!reached) begin
                  ctx_o.run = 1'b0;
                  ctx_o.motor = sense.emergency_stop ? MOT_STOP : seek_dir;
                  ctx_o.leds[LED_E] = sense.emergency_stop;
               end else begin
                  ctx_o.motor = MOT_STOP;
                  unique case (ctx_i.phase)
                     PH_B2_UP: begin
                        ctx_o.next_build = STEP_THREE;
                        ctx_o.phase = PH_IDLE;
                        ctx_o.check = 1'b1;
                     end
                     PH_B4_DOWN: begin
                        ctx_o.next_build = STEP_ONE;
                        ctx_o.leds[LED_W] = 1'b0;
                        ctx_o.leds[LED_B] = 1'b0;
                        ctx_o.phase = PH_IDLE;
                        ctx_o.check = 1'b1;
                     end
                     PH_D1_UP: begin
                        cnt_o = load_wait(cfg[CFG_PAUSE_AT_TOP]);
                        ctx_o.phase = PH_D1_PAUSE;
                     end
                     PH_D2_UP: begin
                        ctx_o.next_dismantle = STEP_THREE;
                        ctx_o.phase = PH_IDLE;
                        ctx_o.run = 1'b0;
                     end
                     default: begin
                        // bottom reached in dismantle step three
                        cnt_o = load_wait(cfg[CFG_WAIT_BEFORE_HOOKS_IN]);
                        ctx_o.phase = PH_D3_WAIT;
                     end
                  endcase
               end
            end
            default: begin
               ctx_o.phase = PH_IDLE;
               ctx_o.run = 1'b0;
            end
         endcase
      end
   end

endmodule

>>> src/lift_build_dismantle_sequencer_unit.sv
// Top level of the lift build/dismantle sequencer.
`timescale 1ns / 1ps
// Path: a tick beat accepted into the input register gives a result beat that
//   can be taken from the result register (input register, then result register).
// Throughput: one tick per cycle unless rsp_stall holds the result; all phase
//   changes a tick causes run through seven chained evaluations between registers.
// Reset is synchronous: sequencer state clears to idle, step one, counter zero,
//   and the timing registers return to their defaults. No clearing pass.

module lift_build_dismantle_sequencer_unit #(
   parameter int COUNT_WIDTH = lbds_pkg::COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // tick channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_btn_build,
   input  logic                              req_btn_dismantle,
   input  logic                              req_emergency_stop,
   input  logic                              req_top_switch,
   input  logic                              req_bottom_switch,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_motor_drive,
   output logic                              rsp_hooks_out,
   output logic                              rsp_led_build,
   output logic                              rsp_led_dismantle,
   output logic                              rsp_led_active,
   output logic                              rsp_led_emergency,
   output logic                              rsp_busy_res,
   output logic [2:0]                        rsp_build_step,
   output logic [1:0]                        rsp_dismantle_step,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lbds_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [lbds_pkg::CFG_WIDTH-1:0]    csr_wdata
);
   import lbds_pkg::*;

   cfg_type cfg;

   // input stage
   logic      in_valid_ff;
   sense_type sense_ff;
   logic      advance;

   // sequencer state
   phase_type              phase_ff;
   logic [1:0]             next_build_ff;
   logic [1:0]             next_dismantle_ff;
   logic [COUNT_WIDTH-1:0] wait_cnt_ff;
   logic [1:0]             motor_ff;
   logic                   hooks_ff;
   logic [3:0]             leds_ff;

   // result stage
   logic       out_valid_ff;
   logic [1:0] out_motor_ff;
   logic       out_hooks_ff;
   logic [3:0] out_leds_ff;
   logic       out_busy_ff;
   logic [2:0] out_build_step_ff;
   logic [1:0] out_dismantle_step_ff;

   ctx_type                ctx_chain [STEP_PASSES+1];
   logic [COUNT_WIDTH-1:0] cnt_chain [STEP_PASSES+1];
   ctx_type                ctx_in;
   logic [COUNT_WIDTH-1:0] cnt_in;

   lbds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign csr_ready = 1'b1;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         sense_ff <= '{btn_build:      req_btn_build,
                       btn_dismantle:  req_btn_dismantle,
                       emergency_stop: req_emergency_stop,
                       top_switch:     req_top_switch,
                       bottom_switch:  req_bottom_switch};
      end
   end

   assign ctx_chain[0] = '{phase:          phase_ff,
                           next_build:     next_build_ff,
                           next_dismantle: next_dismantle_ff,
                           motor:          motor_ff,
                           hooks:          hooks_ff,
                           leds:           leds_ff,
                           check:          1'b0,
                           run:            1'b1};
   assign cnt_chain[0] = wait_cnt_ff;

   for (genvar g = 0; g < STEP_PASSES; g++) begin : g_pass
      lbds_pass #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_pass (
         .cfg   (cfg),
         .sense (sense_ff),
         .ctx_i (ctx_chain[g]),
         .cnt_i (cnt_chain[g]),
         .ctx_o (ctx_chain[g+1]),
         .cnt_o (cnt_chain[g+1])
      );
   end

   // the dismantle check flag is always consumed within the tick
   assign ctx_in = ctx_chain[STEP_PASSES];
   assign cnt_in = cnt_chain[STEP_PASSES];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         next_build_ff     <= STEP_ONE;
         next_dismantle_ff <= STEP_ONE;
         wait_cnt_ff       <= '0;
         motor_ff          <= MOT_STOP;
         hooks_ff          <= 1'b0;
         leds_ff           <= '0;
         out_valid_ff      <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff          <= ctx_in.phase;
            next_build_ff     <= ctx_in.next_build;
            next_dismantle_ff <= ctx_in.next_dismantle;
            wait_cnt_ff       <= cnt_in;
            motor_ff          <= ctx_in.motor;
            hooks_ff          <= ctx_in.hooks;
            leds_ff           <= ctx_in.leds;
            out_valid_ff      <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff      <= 1'b0;
         end
      end
      if (advance) begin
         out_motor_ff          <= ctx_in.motor;
         out_hooks_ff          <= ctx_in.hooks;
         out_leds_ff           <= ctx_in.leds;
         out_busy_ff           <= (ctx_in.phase != PH_IDLE);
         out_build_step_ff     <= {1'b0, ctx_in.next_build} + 3'd1;
         out_dismantle_step_ff <= ctx_in.next_dismantle + 2'd1;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_motor_drive    = out_motor_ff;
   assign rsp_hooks_out      = out_hooks_ff;
   assign rsp_led_build      = out_leds_ff[LED_B];
   assign rsp_led_dismantle  = out_leds_ff[LED_D];
   assign rsp_led_active     = out_leds_ff[LED_W];
   assign rsp_led_emergency  = out_leds_ff[LED_E];
   assign rsp_busy_res       = out_busy_ff;
   assign rsp_build_step     = out_build_step_ff;
   assign rsp_dismantle_step = out_dismantle_step_ff;

endmodule

>>> src/lbds_checker.sv
// Port-level checks for the sequencer top level, bound onto it.
`timescale 1ns / 1ps

module lbds_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [1:0]                        rsp_motor_drive,
   input logic                              rsp_busy_res,
   input logic [2:0]                        rsp_build_step,
   input logic [1:0]                        rsp_dismantle_step
);
   import lbds_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_motor_drive)
         && $stable(rsp_busy_res) && $stable(rsp_build_step)
         && $stable(rsp_dismantle_step))
      else $error("stalled result beat changed");

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat valid after reset");

   // the motor only runs while a step is in progress
   a_motor_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_motor_drive == MOT_UP || rsp_motor_drive == MOT_DOWN)
         |-> rsp_busy_res)
      else $error("motor running with no step in progress");

   // step numbers and the motor code stay in range
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_build_step != 3'd0) && (rsp_build_step <= 3'd4)
         && (rsp_dismantle_step != 2'd0)
         && (rsp_motor_drive == MOT_STOP || rsp_motor_drive == MOT_UP
             || rsp_motor_drive == MOT_DOWN))
      else $error("step number or motor code out of range");

endmodule

bind lift_build_dismantle_sequencer_unit lbds_checker u_lbds_checker (.*);
